### rtl/core/tcw_pkg.sv
`timescale 1ns / 1ps

package tcw_pkg;

	localparam int COLUMNS    = 80;
	localparam int ROWS       = 25;
	localparam int TAB_SPACES = 4;

	localparam int CELLS   = ROWS * COLUMNS;
	localparam int ADDR_W  = $clog2(CELLS);
	localparam int CNT_W   = $clog2(CELLS + 1);
	localparam int RPOS_W  = $clog2(ROWS);
	localparam int CPOS_W  = $clog2(COLUMNS);
	localparam int TAB_W   = $clog2(TAB_SPACES + 1);
	localparam int QDEPTH  = 4;
	localparam int QPTR_W  = $clog2(QDEPTH);
	localparam int QCNT_W  = $clog2(QDEPTH + 1);

	localparam int CMD_W   = 2;
	localparam int CHAR_W  = 8;
	localparam int INDEX_W = 11;
	localparam int COLOR_W = 8;
	localparam int ROW_W   = 5;
	localparam int COL_W   = 7;
	localparam int NIB_W   = 4;
	localparam int CFG_IDX_W = 1;

	localparam logic [CMD_W-1:0] CMD_PUT   = 2'd0;
	localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_FORE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BACK = 1'd1;

	localparam logic [NIB_W-1:0] FORE_RESET = 4'h7;
	localparam logic [NIB_W-1:0] BACK_RESET = 4'h0;

	localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
	localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
	localparam logic [CHAR_W-1:0] CH_NL    = 8'h0A;
	localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

	localparam logic [15:0] RESET_CELL = 16'h0720;

	typedef struct packed {
		logic [CMD_W-1:0]   cmd;
		logic [CHAR_W-1:0]  char_code;
		logic [INDEX_W-1:0] cell_index;
	} item_t;

	typedef struct packed {
		logic [CHAR_W-1:0]  cell_char;
		logic [COLOR_W-1:0] cell_color;
		logic [ROW_W-1:0]   cursor_row;
		logic [COL_W-1:0]   cursor_col;
	} result_t;

	typedef enum logic [2:0] {
		OP_PUT,
		OP_TAB,
		OP_NL,
		OP_BS,
		OP_READ,
		OP_CLEAR,
		OP_NOP
	} op_t;

	typedef struct packed {
		op_t                op;
		logic [CHAR_W-1:0]  ch;
		logic [INDEX_W-1:0] idx;
	} q_entry_t;

	typedef enum logic [3:0] {
		ST_INIT,
		ST_IDLE,
		ST_PUT,
		ST_SCROLL,
		ST_NEXT,
		ST_BS,
		ST_RDOUT,
		ST_CLEAR
	} back_state_t;

endpackage

### rtl/core/tcw_front.sv
`timescale 1ns / 1ps

module tcw_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  tcw_pkg::item_t   item,
	input  logic             init_busy,
	output logic             busy,
	input  logic             q_pop,
	output logic             q_valid,
	output tcw_pkg::q_entry_t q_entry
);

	tcw_pkg::q_entry_t              q_mem_q [tcw_pkg::QDEPTH];
	logic [tcw_pkg::QPTR_W-1:0]     wr_ptr_q;
	logic [tcw_pkg::QPTR_W-1:0]     rd_ptr_q;
	logic [tcw_pkg::QCNT_W-1:0]     count_q;
	tcw_pkg::q_entry_t              cls;
	logic                           push;
	logic                           pop;

	always_comb begin
		cls.ch  = item.char_code;
		cls.idx = item.cell_index;
		case (item.cmd)
			tcw_pkg::CMD_PUT: begin
				case (item.char_code)
					tcw_pkg::CH_NL:  cls.op = tcw_pkg::OP_NL;
					tcw_pkg::CH_TAB: cls.op = tcw_pkg::OP_TAB;
					tcw_pkg::CH_BS:  cls.op = tcw_pkg::OP_BS;
					default:         cls.op = tcw_pkg::OP_PUT;
				endcase
			end
			tcw_pkg::CMD_READ: begin
				if (32'(item.cell_index) < tcw_pkg::CELLS) begin
					cls.op = tcw_pkg::OP_READ;
				end else begin
					cls.op = tcw_pkg::OP_NOP;
				end
			end
			tcw_pkg::CMD_CLEAR: cls.op = tcw_pkg::OP_CLEAR;
			default:            cls.op = tcw_pkg::OP_NOP;
		endcase
	end

	assign busy    = init_busy || (count_q == tcw_pkg::QCNT_W'(tcw_pkg::QDEPTH));
	assign push    = start && !busy;
	assign q_valid = (count_q != '0);
	assign pop     = q_pop && q_valid;
	assign q_entry = q_mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			q_mem_q[wr_ptr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + tcw_pkg::QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + tcw_pkg::QPTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + tcw_pkg::QCNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - tcw_pkg::QCNT_W'(1);
			end
		end
	end

endmodule

### rtl/core/tcw_back.sv
`timescale 1ns / 1ps

module tcw_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        q_valid,
	input  tcw_pkg::q_entry_t           q_entry,
	output logic                        q_pop,
	input  logic [tcw_pkg::COLOR_W-1:0] color,
	output logic                        init_busy,
	output logic                        done,
	output tcw_pkg::result_t            result
);

	logic [15:0] mem [tcw_pkg::CELLS];
	logic [15:0] rd_data_q;

	tcw_pkg::back_state_t           state_q, state_d;
	logic [tcw_pkg::CNT_W-1:0]      cnt_q, cnt_d;
	logic [tcw_pkg::RPOS_W-1:0]     row_q, row_d;
	logic [tcw_pkg::CPOS_W-1:0]     col_q, col_d;
	logic [tcw_pkg::CHAR_W-1:0]     ch_q, ch_d;
	logic [tcw_pkg::TAB_W-1:0]      tab_q, tab_d;
	logic                           done_q, done_d;
	tcw_pkg::result_t               res_q, res_d;

	logic                           mem_we;
	logic [tcw_pkg::ADDR_W-1:0]     mem_waddr;
	logic [15:0]                    mem_wdata;
	logic                           mem_re;
	logic [tcw_pkg::ADDR_W-1:0]     mem_raddr;
	logic [tcw_pkg::ADDR_W-1:0]     cur_addr;
	logic [15:0]                    blank;
	logic                           last_row;
	logic                           last_col;

	assign cur_addr = tcw_pkg::ADDR_W'(row_q) * tcw_pkg::ADDR_W'(tcw_pkg::COLUMNS)
		+ tcw_pkg::ADDR_W'(col_q);
	assign blank    = {color, tcw_pkg::CH_SPACE};
	assign last_row = (row_q == tcw_pkg::RPOS_W'(tcw_pkg::ROWS - 1));
	assign last_col = (col_q == tcw_pkg::CPOS_W'(tcw_pkg::COLUMNS - 1));

	always_comb begin
		state_d   = state_q;
		cnt_d     = cnt_q;
		row_d     = row_q;
		col_d     = col_q;
		ch_d      = ch_q;
		tab_d     = tab_q;
		done_d    = 1'b0;
		res_d     = res_q;
		q_pop     = 1'b0;
		mem_we    = 1'b0;
		mem_waddr = cur_addr;
		mem_wdata = blank;
		mem_re    = 1'b0;
		mem_raddr = tcw_pkg::ADDR_W'(q_entry.idx);
		case (state_q)
			tcw_pkg::ST_INIT: begin
				mem_we    = 1'b1;
				mem_waddr = cnt_q[tcw_pkg::ADDR_W-1:0];
				mem_wdata = tcw_pkg::RESET_CELL;
				if (cnt_q == tcw_pkg::CNT_W'(tcw_pkg::CELLS - 1)) begin
					state_d = tcw_pkg::ST_IDLE;
				end else begin
					cnt_d = cnt_q + tcw_pkg::CNT_W'(1);
				end
			end
			tcw_pkg::ST_IDLE: begin
				if (q_valid) begin
					q_pop = 1'b1;
					tab_d = '0;
					cnt_d = '0;
					ch_d  = q_entry.ch;
					case (q_entry.op)
						tcw_pkg::OP_PUT: state_d = tcw_pkg::ST_PUT;
						tcw_pkg::OP_TAB: begin
							ch_d    = tcw_pkg::CH_SPACE;
							tab_d   = tcw_pkg::TAB_W'(tcw_pkg::TAB_SPACES - 1);
							state_d = tcw_pkg::ST_PUT;
						end
						tcw_pkg::OP_NL: begin
							col_d = '0;
							if (last_row) begin
								state_d = tcw_pkg::ST_SCROLL;
							end else begin
								row_d   = row_q + tcw_pkg::RPOS_W'(1);
								state_d = tcw_pkg::ST_NEXT;
							end
						end
						tcw_pkg::OP_BS: begin
							if (col_q != '0) begin
								col_d = col_q - tcw_pkg::CPOS_W'(1);
							end else if (row_q != '0) begin
								row_d = row_q - tcw_pkg::RPOS_W'(1);
								col_d = tcw_pkg::CPOS_W'(tcw_pkg::COLUMNS - 1);
							end
							state_d = tcw_pkg::ST_BS;
						end
						tcw_pkg::OP_READ: begin
							mem_re  = 1'b1;
							state_d = tcw_pkg::ST_RDOUT;
						end
						tcw_pkg::OP_CLEAR: state_d = tcw_pkg::ST_CLEAR;
						default:           state_d = tcw_pkg::ST_NEXT;
					endcase
				end
			end
			tcw_pkg::ST_PUT: begin
				mem_we    = 1'b1;
				mem_wdata = {color, ch_q};
				if (last_col) begin
					col_d = '0;
					cnt_d = '0;
					if (last_row) begin
						state_d = tcw_pkg::ST_SCROLL;
					end else begin
						row_d   = row_q + tcw_pkg::RPOS_W'(1);
						state_d = tcw_pkg::ST_NEXT;
					end
				end else begin
					col_d   = col_q + tcw_pkg::CPOS_W'(1);
					state_d = tcw_pkg::ST_NEXT;
				end
			end
			tcw_pkg::ST_SCROLL: begin
				if (cnt_q < tcw_pkg::CNT_W'(tcw_pkg::CELLS - tcw_pkg::COLUMNS)) begin
					mem_re    = 1'b1;
					mem_raddr = tcw_pkg::ADDR_W'(cnt_q + tcw_pkg::CNT_W'(tcw_pkg::COLUMNS));
				end
				if (cnt_q != '0) begin
					mem_we    = 1'b1;
					mem_waddr = tcw_pkg::ADDR_W'(cnt_q - tcw_pkg::CNT_W'(1));
					if (cnt_q <= tcw_pkg::CNT_W'(tcw_pkg::CELLS - tcw_pkg::COLUMNS)) begin
						mem_wdata = rd_data_q;
					end
				end
				if (cnt_q == tcw_pkg::CNT_W'(tcw_pkg::CELLS)) begin
					state_d = tcw_pkg::ST_NEXT;
				end else begin
					cnt_d = cnt_q + tcw_pkg::CNT_W'(1);
				end
			end
			tcw_pkg::ST_NEXT: begin
				if (tab_q != '0) begin
					tab_d   = tab_q - tcw_pkg::TAB_W'(1);
					state_d = tcw_pkg::ST_PUT;
				end else begin
					done_d           = 1'b1;
					res_d.cell_char  = '0;
					res_d.cell_color = '0;
					res_d.cursor_row = tcw_pkg::ROW_W'(row_q);
					res_d.cursor_col = tcw_pkg::COL_W'(col_q);
					state_d          = tcw_pkg::ST_IDLE;
				end
			end
			tcw_pkg::ST_BS: begin
				mem_we  = 1'b1;
				state_d = tcw_pkg::ST_NEXT;
			end
			tcw_pkg::ST_RDOUT: begin
				done_d           = 1'b1;
				res_d.cell_char  = rd_data_q[7:0];
				res_d.cell_color = rd_data_q[15:8];
				res_d.cursor_row = tcw_pkg::ROW_W'(row_q);
				res_d.cursor_col = tcw_pkg::COL_W'(col_q);
				state_d          = tcw_pkg::ST_IDLE;
			end
			tcw_pkg::ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = cnt_q[tcw_pkg::ADDR_W-1:0];
				if (cnt_q == tcw_pkg::CNT_W'(tcw_pkg::CELLS - 1)) begin
					row_d   = '0;
					col_d   = '0;
					state_d = tcw_pkg::ST_NEXT;
				end else begin
					cnt_d = cnt_q + tcw_pkg::CNT_W'(1);
				end
			end
			default: state_d = tcw_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rd_data_q <= mem[mem_raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tcw_pkg::ST_INIT;
			cnt_q   <= '0;
			row_q   <= '0;
			col_q   <= '0;
			tab_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			row_q   <= row_d;
			col_q   <= col_d;
			tab_q   <= tab_d;
			done_q  <= done_d;
		end
	end

	always_ff @(posedge clk) begin
		ch_q  <= ch_d;
		res_q <= res_d;
	end

	assign init_busy = (state_q == tcw_pkg::ST_INIT);
	assign done      = done_q;
	assign result    = res_q;

endmodule

### rtl/core/text_console_writer.sv
`timescale 1ns / 1ps
// An ordinary character passes the queue, then the IDLE, PUT and NEXT states before done; a newline
// goes from IDLE to NEXT, a backspace through BS, and a wrap at the bottom row adds a SCROLL pass.
// A tab repeats the character path once per space; a clear blanks every cell and homes the cursor.
// The store engine finishes each character before it takes the next from a four-entry queue.
// After reset, busy stays high while all CELLS (2000) cells of the screen store are blanked.
// The done strobe lasts one cycle and cannot be stalled by the receiver.

module text_console_writer (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  tcw_pkg::item_t                item,
	output logic                          done,
	output tcw_pkg::result_t              result,
	input  logic                          cfg_we,
	input  logic [tcw_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [tcw_pkg::NIB_W-1:0]     cfg_data
);

	logic [tcw_pkg::NIB_W-1:0] fore_q;
	logic [tcw_pkg::NIB_W-1:0] back_q;
	logic                      init_busy;
	logic                      q_pop;
	logic                      q_valid;
	tcw_pkg::q_entry_t         q_entry;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fore_q <= tcw_pkg::FORE_RESET;
			back_q <= tcw_pkg::BACK_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				tcw_pkg::REG_FORE: fore_q <= cfg_data;
				tcw_pkg::REG_BACK: back_q <= cfg_data;
				default: ;
			endcase
		end
	end

	tcw_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.item      (item),
		.init_busy (init_busy),
		.busy      (busy),
		.q_pop     (q_pop),
		.q_valid   (q_valid),
		.q_entry   (q_entry)
	);

	tcw_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_entry   (q_entry),
		.q_pop     (q_pop),
		.color     ({back_q, fore_q}),
		.init_busy (init_busy),
		.done      (done),
		.result    (result)
	);

endmodule
